// ----- src/abd_pkg.sv -----
package abd_pkg;

	// Configuration port
	localparam int unsigned CfgAddrW = 5;
	localparam int unsigned CfgDataW = 32;

	localparam logic [2:0] RegScoreThreshold = 3'd0;
	localparam logic [2:0] RegStride         = 3'd1;
	localparam logic [2:0] RegAnchor0Width   = 3'd2;
	localparam logic [2:0] RegAnchor0Height  = 3'd3;
	localparam logic [2:0] RegAnchor1Width   = 3'd4;
	localparam logic [2:0] RegAnchor1Height  = 3'd5;

	localparam logic [15:0] RstScoreThreshold = 16'd32768;
	localparam logic [8:0]  RstStride         = 9'd8;
	localparam logic [15:0] RstAnchor0Width   = 16'd256;
	localparam logic [15:0] RstAnchor0Height  = 16'd256;
	localparam logic [15:0] RstAnchor1Width   = 16'd512;
	localparam logic [15:0] RstAnchor1Height  = 16'd512;

	// Exponential unit: Q.28 value, Taylor series on x/8, then squared three times
	localparam int unsigned ExpW        = 31;
	localparam int unsigned TaylorSteps = 6;
	localparam int unsigned SquareSteps = 3;
	localparam int unsigned ExpLat      = 2 + 3 * TaylorSteps + 1 + 2 * SquareSteps;
	localparam logic [28:0] ExpOne      = 29'h1000_0000;

	// Division by a small constant: floor(n * Recip >> 30), exact for n below 2^30
	localparam int unsigned RecipShift = 30;
	localparam logic [29:0] Recip5     = 30'd214748365;

	// Taylor terms two to seven: divisor reciprocal and half divisor for rounding
	localparam logic [29:0] TaylorRecip [TaylorSteps] = '{
		30'd536870912, 30'd357913942, 30'd268435456,
		30'd214748365, 30'd178956971, 30'd153391690
	};
	localparam logic [1:0] TaylorHalf [TaylorSteps] = '{
		2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3
	};

	typedef struct packed {
		logic [8:0]         row;
		logic [8:0]         column;
		logic               anchor_index;
		logic [15:0]        face_score;
		logic signed [15:0] delta_cx;
		logic signed [15:0] delta_cy;
		logic signed [15:0] delta_w;
		logic signed [15:0] delta_h;
	} item_t;

	typedef struct packed {
		logic signed [23:0] xmin;
		logic signed [23:0] ymin;
		logic signed [23:0] xmax;
		logic signed [23:0] ymax;
		logic [15:0]        box_score;
	} result_t;

	typedef struct packed {
		logic [15:0] score_threshold;
		logic [8:0]  stride;
		logic [15:0] anchor0_width;
		logic [15:0] anchor0_height;
		logic [15:0] anchor1_width;
		logic [15:0] anchor1_height;
	} cfg_t;

	// Fields that ride alongside the exponential units
	typedef struct packed {
		logic [8:0]         row;
		logic [8:0]         column;
		logic               anchor_index;
		logic [15:0]        face_score;
		logic signed [15:0] delta_cx;
		logic signed [15:0] delta_cy;
	} side_t;

endpackage

// ----- src/abd_cfg.sv -----
module abd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abd_pkg::CfgAddrW-1:0]  paddr,
	input  logic [abd_pkg::CfgDataW-1:0]  pwdata,
	output logic [abd_pkg::CfgDataW-1:0]  prdata,
	output logic                          pready,
	output abd_pkg::cfg_t                 cfg
);

	logic          wr;
	logic [2:0]    idx;
	abd_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = paddr[abd_pkg::CfgAddrW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= abd_pkg::RstScoreThreshold;
			cfg_q.stride          <= abd_pkg::RstStride;
			cfg_q.anchor0_width   <= abd_pkg::RstAnchor0Width;
			cfg_q.anchor0_height  <= abd_pkg::RstAnchor0Height;
			cfg_q.anchor1_width   <= abd_pkg::RstAnchor1Width;
			cfg_q.anchor1_height  <= abd_pkg::RstAnchor1Height;
		end else if (wr) begin
			case (idx)
				abd_pkg::RegScoreThreshold: cfg_q.score_threshold <= pwdata[15:0];
				abd_pkg::RegStride:         cfg_q.stride          <= pwdata[8:0];
				abd_pkg::RegAnchor0Width:   cfg_q.anchor0_width   <= pwdata[15:0];
				abd_pkg::RegAnchor0Height:  cfg_q.anchor0_height  <= pwdata[15:0];
				abd_pkg::RegAnchor1Width:   cfg_q.anchor1_width   <= pwdata[15:0];
				abd_pkg::RegAnchor1Height:  cfg_q.anchor1_height  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			abd_pkg::RegScoreThreshold: prdata = 32'(cfg_q.score_threshold);
			abd_pkg::RegStride:         prdata = 32'(cfg_q.stride);
			abd_pkg::RegAnchor0Width:   prdata = 32'(cfg_q.anchor0_width);
			abd_pkg::RegAnchor0Height:  prdata = 32'(cfg_q.anchor0_height);
			abd_pkg::RegAnchor1Width:   prdata = 32'(cfg_q.anchor1_width);
			abd_pkg::RegAnchor1Height:  prdata = 32'(cfg_q.anchor1_height);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ----- src/abd_exp.sv -----
module abd_exp (
	input  logic                      clk,
	input  logic signed [15:0]        delta,
	output logic [abd_pkg::ExpW-1:0]  scale
);

	typedef struct packed {
		logic [25:0] y;
		logic        neg;
		logic [28:0] sum;
	} tay_carry_t;

	logic [15:0]     mag;
	logic [55:0]     yp_s1;
	logic            neg_s1;
	tay_carry_t      car_s2;
	logic [25:0]     term_s2;
	tay_carry_t      tay_car  [abd_pkg::TaylorSteps+1];
	logic [25:0]     tay_term [abd_pkg::TaylorSteps+1];
	logic [28:0]     sum_s21;
	logic [30:0]     sq_in    [abd_pkg::SquareSteps+1];

	assign mag = delta[15] ? (16'(~delta) + 16'd1) : 16'(delta);

	// y = round(|delta| * 8192 / 5), the exponent argument over eight in Q.28
	always_ff @(posedge clk) begin
		yp_s1      <= 56'(59'({mag, 13'd2}) * 59'(abd_pkg::Recip5));
		neg_s1     <= delta[15];
		car_s2.y   <= yp_s1[55:30];
		car_s2.neg <= neg_s1;
		car_s2.sum <= abd_pkg::ExpOne;
		term_s2    <= yp_s1[55:30];
	end

	assign tay_car[0]  = car_s2;
	assign tay_term[0] = term_s2;

	// One step per term: multiply by y, round, divide by k; the previous term joins the sum
	for (genvar j = 0; j < abd_pkg::TaylorSteps; j++) begin : g_tay
		localparam bit PrevOdd = (j % 2) == 0;
		tay_carry_t  car_s1;
		tay_carry_t  car_s2;
		tay_carry_t  car_s3;
		logic [51:0] prod_s1;
		logic [24:0] num_s2;
		logic [54:0] quo_s3;

		always_ff @(posedge clk) begin
			prod_s1     <= 52'(tay_term[j]) * 52'(tay_car[j].y);
			car_s1.y    <= tay_car[j].y;
			car_s1.neg  <= tay_car[j].neg;
			car_s1.sum  <= (tay_car[j].neg && PrevOdd) ?
				tay_car[j].sum - 29'(tay_term[j]) : tay_car[j].sum + 29'(tay_term[j]);
			num_s2      <= 25'(prod_s1[51:28]) + 25'(prod_s1[27]) +
				25'(abd_pkg::TaylorHalf[j]);
			car_s2      <= car_s1;
			quo_s3      <= 55'(num_s2) * 55'(abd_pkg::TaylorRecip[j]);
			car_s3      <= car_s2;
		end

		assign tay_car[j+1]  = car_s3;
		assign tay_term[j+1] = 26'(quo_s3[54:30]);
	end

	// The last term has odd order
	always_ff @(posedge clk) begin
		sum_s21 <= tay_car[abd_pkg::TaylorSteps].neg ?
			tay_car[abd_pkg::TaylorSteps].sum - 29'(tay_term[abd_pkg::TaylorSteps]) :
			tay_car[abd_pkg::TaylorSteps].sum + 29'(tay_term[abd_pkg::TaylorSteps]);
	end

	assign sq_in[0] = 31'(sum_s21);

	for (genvar i = 0; i < abd_pkg::SquareSteps; i++) begin : g_sq
		logic [61:0] prod_s1;
		logic [30:0] res_s2;

		always_ff @(posedge clk) begin
			prod_s1 <= 62'(sq_in[i]) * 62'(sq_in[i]);
			res_s2  <= 31'(prod_s1[61:28]) + 31'(prod_s1[27]);
		end

		assign sq_in[i+1] = res_s2;
	end

	assign scale = sq_in[abd_pkg::SquareSteps];

endmodule

// ----- src/abd_box.sv -----
module abd_box (
	input  logic                      clk,
	input  logic                      arst_n,
	input  abd_pkg::cfg_t             cfg,
	input  logic                      live,
	input  abd_pkg::side_t            side,
	input  logic [abd_pkg::ExpW-1:0]  scale_w,
	input  logic [abd_pkg::ExpW-1:0]  scale_h,
	output logic                      strobe,
	output abd_pkg::result_t          result
);

	logic [15:0]        aw;
	logic [15:0]        ah;
	logic [15:0]        mag_x;
	logic [15:0]        mag_y;

	logic               live_s1, live_s2, live_s3, live_s4, live_s5;
	logic [15:0]        score_s1, score_s2, score_s3, score_s4, score_s5;

	logic [18:0]        cen_x_s1, cen_y_s1, cen_x_s2, cen_y_s2, cen_x_s3, cen_y_s3;
	logic               neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic [31:0]        shp_x_s1, shp_y_s1;
	logic [29:0]        shv_x_s2, shv_y_s2;
	logic [57:0]        shq_x_s3, shq_y_s3;
	logic [46:0]        hp_w_s1, hp_h_s1;
	logic [29:0]        half_w_s2, half_h_s2, half_w_s3, half_h_s3, half_w_s4, half_h_s4;
	logic signed [35:0] ctr_x_s4, ctr_y_s4;
	logic signed [36:0] lo_x_s5, hi_x_s5, lo_y_s5, hi_y_s5;

	logic               strobe_q;
	abd_pkg::result_t   result_q;

	// Round half away from zero to Q.4, then clamp to the 24-bit range
	function automatic logic signed [23:0] to_corner(input logic signed [36:0] v);
		logic signed [36:0] r;
		logic signed [24:0] q;
		logic signed [23:0] c;
		r = v + (v[36] ? 37'sd2047 : 37'sd2048);
		q = 25'(r >>> 12);
		if (q > 25'sd8388607)
			c = 24'sh7FFFFF;
		else if (q < -25'sd8388608)
			c = 24'sh800000;
		else
			c = q[23:0];
		return c;
	endfunction

	assign aw    = side.anchor_index ? cfg.anchor1_width  : cfg.anchor0_width;
	assign ah    = side.anchor_index ? cfg.anchor1_height : cfg.anchor0_height;
	assign mag_x = side.delta_cx[15] ? (16'(~side.delta_cx) + 16'd1) : 16'(side.delta_cx);
	assign mag_y = side.delta_cy[15] ? (16'(~side.delta_cy) + 16'd1) : 16'(side.delta_cy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1  <= 1'b0;
			live_s2  <= 1'b0;
			live_s3  <= 1'b0;
			live_s4  <= 1'b0;
			live_s5  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			live_s1  <= live;
			live_s2  <= live_s1;
			live_s3  <= live_s2;
			live_s4  <= live_s3;
			live_s5  <= live_s4;
			strobe_q <= live_s5;
		end
	end

	always_ff @(posedge clk) begin
		// centre (2*cell+1)*stride, offset |delta|*size, scaled size
		score_s1 <= side.face_score;
		cen_x_s1 <= 19'({side.column, 1'b1}) * 19'(cfg.stride);
		cen_y_s1 <= 19'({side.row, 1'b1}) * 19'(cfg.stride);
		shp_x_s1 <= 32'(mag_x) * 32'(aw);
		shp_y_s1 <= 32'(mag_y) * 32'(ah);
		neg_x_s1 <= side.delta_cx[15];
		neg_y_s1 <= side.delta_cy[15];
		hp_w_s1  <= 47'(aw) * 47'(scale_w);
		hp_h_s1  <= 47'(ah) * 47'(scale_h);

		// divide by ten as halve then divide by five, rounding in the halve
		score_s2  <= score_s1;
		cen_x_s2  <= cen_x_s1;
		cen_y_s2  <= cen_y_s1;
		neg_x_s2  <= neg_x_s1;
		neg_y_s2  <= neg_y_s1;
		shv_x_s2  <= 30'((33'(shp_x_s1) + 33'd5) >> 1);
		shv_y_s2  <= 30'((33'(shp_y_s1) + 33'd5) >> 1);
		half_w_s2 <= 30'((48'(hp_w_s1) + 48'd65536) >> 17);
		half_h_s2 <= 30'((48'(hp_h_s1) + 48'd65536) >> 17);

		score_s3  <= score_s2;
		cen_x_s3  <= cen_x_s2;
		cen_y_s3  <= cen_y_s2;
		neg_x_s3  <= neg_x_s2;
		neg_y_s3  <= neg_y_s2;
		shq_x_s3  <= 58'(58'(shv_x_s2) * 58'(abd_pkg::Recip5));
		shq_y_s3  <= 58'(58'(shv_y_s2) * 58'(abd_pkg::Recip5));
		half_w_s3 <= half_w_s2;
		half_h_s3 <= half_h_s2;

		// centre in Q.16 plus the signed offset
		score_s4  <= score_s3;
		ctr_x_s4  <= neg_x_s3 ?
			{2'b00, cen_x_s3, 15'd0} - 36'(shq_x_s3[57:30]) :
			{2'b00, cen_x_s3, 15'd0} + 36'(shq_x_s3[57:30]);
		ctr_y_s4  <= neg_y_s3 ?
			{2'b00, cen_y_s3, 15'd0} - 36'(shq_y_s3[57:30]) :
			{2'b00, cen_y_s3, 15'd0} + 36'(shq_y_s3[57:30]);
		half_w_s4 <= half_w_s3;
		half_h_s4 <= half_h_s3;

		score_s5 <= score_s4;
		lo_x_s5  <= 37'(ctr_x_s4) - 37'(half_w_s4);
		hi_x_s5  <= 37'(ctr_x_s4) + 37'(half_w_s4);
		lo_y_s5  <= 37'(ctr_y_s4) - 37'(half_h_s4);
		hi_y_s5  <= 37'(ctr_y_s4) + 37'(half_h_s4);

		result_q.xmin      <= to_corner(lo_x_s5);
		result_q.ymin      <= to_corner(lo_y_s5);
		result_q.xmax      <= to_corner(hi_x_s5);
		result_q.ymax      <= to_corner(hi_y_s5);
		result_q.box_score <= score_s5;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ----- src/anchor_box_decode.sv -----
// Channel  Ports                                   Dir  Beat
// item     start, busy, item                       in   one anchor record (item_t)
// result   strobe, result                          out  one corner box with score (result_t)
// config   psel, penable, pwrite, paddr, pwdata,   in   one 32-bit register write or read
//          prdata, pready
//
// One record is taken in every cycle; busy stays low.
// A box reaches the result ports once its record has passed 1 entry stage, 27 stages of the
// exponential units (Taylor series, three squarings) and 6 stages of box arithmetic.
// Records scoring below the threshold leave no beat.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall: strobe is high for one cycle per box.
module anchor_box_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  abd_pkg::item_t                item,
	output logic                          strobe,
	output abd_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abd_pkg::CfgAddrW-1:0]  paddr,
	input  logic [abd_pkg::CfgDataW-1:0]  pwdata,
	output logic [abd_pkg::CfgDataW-1:0]  prdata,
	output logic                          pready
);

	abd_pkg::cfg_t               cfg;
	logic                        live_s1;
	abd_pkg::side_t              side_s1;
	logic signed [15:0]          dw_s1;
	logic signed [15:0]          dh_s1;
	logic [abd_pkg::ExpLat-1:0]  live_q;
	abd_pkg::side_t              side_q [abd_pkg::ExpLat];
	logic [abd_pkg::ExpW-1:0]    scale_w;
	logic [abd_pkg::ExpW-1:0]    scale_h;

	assign busy = 1'b0;

	abd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Drop records below threshold at entry: only the valid bit is cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
			live_q  <= '0;
		end else begin
			live_s1 <= start && !busy && (item.face_score >= cfg.score_threshold);
			live_q  <= {live_q[abd_pkg::ExpLat-2:0], live_s1};
		end
	end

	always_ff @(posedge clk) begin
		side_s1.row          <= item.row;
		side_s1.column       <= item.column;
		side_s1.anchor_index <= item.anchor_index;
		side_s1.face_score   <= item.face_score;
		side_s1.delta_cx     <= item.delta_cx;
		side_s1.delta_cy     <= item.delta_cy;
		dw_s1                <= item.delta_w;
		dh_s1                <= item.delta_h;

		// hold the side fields level with the exponential units
		side_q[0] <= side_s1;
		for (int i = 1; i < abd_pkg::ExpLat; i++)
			side_q[i] <= side_q[i-1];
	end

	abd_exp u_exp_w (
		.clk   (clk),
		.delta (dw_s1),
		.scale (scale_w)
	);

	abd_exp u_exp_h (
		.clk   (clk),
		.delta (dh_s1),
		.scale (scale_h)
	);

	abd_box u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.live    (live_q[abd_pkg::ExpLat-1]),
		.side    (side_q[abd_pkg::ExpLat-1]),
		.scale_w (scale_w),
		.scale_h (scale_h),
		.strobe  (strobe),
		.result  (result)
	);

endmodule
